/* rtl/swtf_pkg.sv */
// ----------------------------------------------------------------------------
// swtf_pkg
// Shared constants, command and status types of the trend feature unit.
// ----------------------------------------------------------------------------
package swtf_pkg;

  localparam int unsigned DEPTH   = 60;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = 46;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned SQRT_STEPS = 22;

  localparam logic [1:0] REG_TREND_SCALE = 2'd0;
  localparam logic [1:0] REG_WIND_LIMIT  = 2'd1;
  localparam logic [1:0] REG_CLOUD_LIMIT = 2'd2;

  localparam logic [15:0] TREND_SCALE_RST = 16'd100;
  localparam logic [7:0]  WIND_LIMIT_RST  = 8'd10;
  localparam logic [6:0]  CLOUD_LIMIT_RST = 7'd80;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE,
    OP_CHECK,
    OP_SWEEP,
    OP_DEN0,
    OP_DEN1,
    OP_MUL,
    OP_NUM,
    OP_SUMX,
    OP_PREP,
    OP_DIVSTEP,
    OP_TREND_DONE,
    OP_SQ0,
    OP_SQ1,
    OP_SQRTSTEP,
    OP_SPR_CHK,
    OP_SPR_PREP,
    OP_SPR_DONE,
    OP_FINAL
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             acc_en;
    logic [IDX_W-1:0] acc_idx;
    logic [1:0]       chan;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             clamp;
  } sts_t;

endpackage

/* rtl/swtf_ctrl.sv */
// ----------------------------------------------------------------------------
// swtf_ctrl
// Sequencer that steps the datapath through write, sweep and arithmetic.
// ----------------------------------------------------------------------------
module swtf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  swtf_pkg::sts_t sts_i,
  output swtf_pkg::cmd_t cmd_o
);
  import swtf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_CHECK, S_SWEEP, S_DEN0, S_DEN1, S_MUL, S_NUM, S_SUMX,
    S_PREP, S_DIV, S_TDONE, S_SQ0, S_SQ1, S_SQRT, S_SCHK, S_SPREP, S_SDIV,
    S_SDONE, S_FINAL, S_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      chan_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_WRITE;
        S_WRITE: state_q <= S_CHECK;
        S_CHECK: begin
          cnt_q <= '0;
          if (sts_i.fill >= CNT_W'(2)) state_q <= S_SWEEP;
          else state_q <= S_OUT;
        end
        S_SWEEP: begin
          if (cnt_q == sts_i.fill) state_q <= S_DEN0;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_DEN0: state_q <= S_DEN1;
        S_DEN1: begin
          chan_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL:  state_q <= S_NUM;
        S_NUM:  state_q <= S_SUMX;
        S_SUMX: state_q <= S_PREP;
        S_PREP: begin
          cnt_q <= '0;
          if (sts_i.clamp) begin
            chan_q  <= chan_q + 1'b1;
            state_q <= (chan_q == 2'd3) ? S_SQ0 : S_MUL;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_TDONE;
        end
        S_TDONE: begin
          chan_q  <= chan_q + 1'b1;
          state_q <= (chan_q == 2'd3) ? S_SQ0 : S_MUL;
        end
        S_SQ0: state_q <= S_SQ1;
        S_SQ1: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_q <= S_SCHK;
        end
        S_SCHK: state_q <= S_SPREP;
        S_SPREP: begin
          cnt_q   <= '0;
          state_q <= sts_i.clamp ? S_FINAL : S_SDIV;
        end
        S_SDIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_SDONE;
        end
        S_SDONE: state_q <= S_FINAL;
        S_FINAL: state_q <= S_OUT;
        S_OUT:   if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.chan    = chan_q;
    cmd_o.rd_addr = cnt_q[IDX_W-1:0];
    cmd_o.acc_idx = IDX_W'(cnt_q - 1'b1);
    case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_WRITE: cmd_o.op = OP_WRITE;
      S_CHECK: cmd_o.op = OP_CHECK;
      S_SWEEP: begin
        cmd_o.op     = OP_SWEEP;
        cmd_o.rd_en  = (cnt_q < sts_i.fill);
        cmd_o.acc_en = (cnt_q != '0);
      end
      S_DEN0:  cmd_o.op = OP_DEN0;
      S_DEN1:  cmd_o.op = OP_DEN1;
      S_MUL:   cmd_o.op = OP_MUL;
      S_NUM:   cmd_o.op = OP_NUM;
      S_SUMX:  cmd_o.op = OP_SUMX;
      S_PREP:  cmd_o.op = OP_PREP;
      S_DIV:   cmd_o.op = OP_DIVSTEP;
      S_TDONE: cmd_o.op = OP_TREND_DONE;
      S_SQ0:   cmd_o.op = OP_SQ0;
      S_SQ1:   cmd_o.op = OP_SQ1;
      S_SQRT:  cmd_o.op = OP_SQRTSTEP;
      S_SCHK:  cmd_o.op = OP_SPR_CHK;
      S_SPREP: cmd_o.op = OP_SPR_PREP;
      S_SDIV:  cmd_o.op = OP_DIVSTEP;
      S_SDONE: cmd_o.op = OP_SPR_DONE;
      S_FINAL: cmd_o.op = OP_FINAL;
      S_OUT:   cmd_o.op = OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/swtf_dp.sv */
// ----------------------------------------------------------------------------
// swtf_dp
// Window memory, running sums, shared divider, square root and feature regs.
// ----------------------------------------------------------------------------
module swtf_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  swtf_pkg::cmd_t cmd_i,
  output swtf_pkg::sts_t sts_o,
  input  logic [15:0]    snr_value_i,
  input  logic [15:0]    latency_value_i,
  input  logic [6:0]     loss_percent_i,
  input  logic [6:0]     obstruction_percent_i,
  input  logic [7:0]     rain_amount_i,
  input  logic [7:0]     wind_speed_i,
  input  logic [6:0]     cloud_percent_i,
  input  logic [10:0]    minute_of_day_i,
  input  logic [15:0]    trend_scale_i,
  input  logic [7:0]     wind_limit_i,
  input  logic [6:0]     cloud_limit_i,
  output logic [7:0]     snr_slope_o,
  output logic [7:0]     snr_spread_o,
  output logic [7:0]     latency_slope_o,
  output logic [7:0]     loss_slope_o,
  output logic [7:0]     obstruction_slope_o,
  output logic [6:0]     weather_score_o,
  output logic [7:0]     day_fraction_o,
  output logic [7:0]     pattern_byte_o,
  output logic           features_fresh_o
);
  import swtf_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  logic [15:0] snr_q, lat_q;
  logic [6:0]  loss_q, obs_q, cloud_q;
  logic [7:0]  rain_q, wind_q;
  logic [10:0] minute_q;

  logic [IDX_W-1:0] slot_q;
  logic [CNT_W-1:0] fill_q;

  logic [10:0] sx_q;
  logic [16:0] sx2_q;
  logic [21:0] sy_q  [4];
  logic [26:0] sxy_q [4];
  logic [37:0] sq_q;
  logic [7:0]  pat_q;

  logic [22:0] t1_q, t2_q, den_q;
  logic [32:0] m1_q, m2_q;
  logic [38:0] dm_q;
  logic signed [35:0] num_q;
  logic [39:0] x_q;
  logic        ge_q, le_q;

  logic [47:0] rem_q, dsh_q;
  logic [7:0]  quo_q;

  logic [43:0] sqa_q, sqb_q, sv_q;
  logic [44:0] res_q, bit_q;

  logic [7:0] trend_q [4];
  logic [7:0] spread_q, day_q, pat_out_q;
  logic [6:0] weather_q;
  logic       fresh_q;

  logic [15:0] r_snr, r_lat;
  logic [6:0]  r_loss, r_obs;
  logic [15:0] scale;
  logic signed [38:0] numx, dx;
  logic [44:0] trial;
  logic [10:0] mm;
  logic [14:0] y17;
  logic [19:0] dprod;
  logic [6:0]  ws;

  assign r_snr  = rdata_q[45:30];
  assign r_lat  = rdata_q[29:14];
  assign r_loss = rdata_q[13:7];
  assign r_obs  = rdata_q[6:0];
  assign scale  = (trend_scale_i == '0) ? 16'd1 : trend_scale_i;
  assign numx   = 39'(num_q);
  assign dx     = $signed(dm_q);
  assign trial  = res_q + bit_q;
  assign mm     = (minute_q > 11'd1439) ? 11'd1439 : minute_q;
  assign y17    = 15'(mm) * 15'd17;
  assign dprod  = 20'(y17[14:5]) * 20'd683;

  always_comb begin
    ws = '0;
    if (rain_q != '0) ws = ws + 7'd50;
    if (wind_q > wind_limit_i) ws = ws + 7'd30;
    if (cloud_q > cloud_limit_i) ws = ws + 7'd20;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) begin
      mem[slot_q] <= {snr_q, lat_q, loss_q, obs_q};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        snr_q    <= snr_value_i;
        lat_q    <= latency_value_i;
        loss_q   <= loss_percent_i;
        obs_q    <= obstruction_percent_i;
        rain_q   <= rain_amount_i;
        wind_q   <= wind_speed_i;
        cloud_q  <= cloud_percent_i;
        minute_q <= minute_of_day_i;
      end
      OP_WRITE: begin
        sx_q  <= '0;
        sx2_q <= '0;
        sq_q  <= '0;
        pat_q <= '0;
        for (int c = 0; c < 4; c++) begin
          sy_q[c]  <= '0;
          sxy_q[c] <= '0;
        end
      end
      OP_SWEEP: begin
        if (cmd_i.acc_en) begin
          sx_q     <= sx_q + 11'(cmd_i.acc_idx);
          sx2_q    <= sx2_q + 17'(cmd_i.acc_idx) * 17'(cmd_i.acc_idx);
          sy_q[0]  <= sy_q[0] + 22'(r_snr);
          sy_q[1]  <= sy_q[1] + 22'(r_lat);
          sy_q[2]  <= sy_q[2] + 22'(r_loss);
          sy_q[3]  <= sy_q[3] + 22'(r_obs);
          sxy_q[0] <= sxy_q[0] + 27'(cmd_i.acc_idx) * 27'(r_snr);
          sxy_q[1] <= sxy_q[1] + 27'(cmd_i.acc_idx) * 27'(r_lat);
          sxy_q[2] <= sxy_q[2] + 27'(cmd_i.acc_idx) * 27'(r_loss);
          sxy_q[3] <= sxy_q[3] + 27'(cmd_i.acc_idx) * 27'(r_obs);
          sq_q     <= sq_q + 38'(32'(r_snr) * 32'(r_snr));
          pat_q    <= pat_q ^ r_snr[7:0];
        end
      end
      OP_DEN0: begin
        t1_q <= 23'(fill_q) * 23'(sx2_q);
        t2_q <= 23'(sx_q) * 23'(sx_q);
      end
      OP_DEN1: den_q <= t1_q - t2_q;
      OP_MUL: begin
        m1_q <= 33'(fill_q) * 33'(sxy_q[cmd_i.chan]);
        m2_q <= 33'(sx_q) * 33'(sy_q[cmd_i.chan]);
        dm_q <= 39'(den_q) * 39'(scale);
      end
      OP_NUM: num_q <= $signed({3'b000, m1_q}) - $signed({3'b000, m2_q});
      OP_SUMX: begin
        ge_q <= (numx >= dx);
        le_q <= (numx <= -dx);
        x_q  <= 40'(numx + dx);
      end
      OP_PREP: begin
        rem_q <= {x_q, 8'd0} - 48'(x_q);
        dsh_q <= {1'b0, dm_q, 8'd0};
        quo_q <= '0;
      end
      OP_DIVSTEP: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[6:0], 1'b1};
        end else begin
          quo_q <= {quo_q[6:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      OP_SQ0: begin
        sqa_q <= 44'(fill_q) * 44'(sq_q);
        sqb_q <= 44'(sy_q[0]) * 44'(sy_q[0]);
      end
      OP_SQ1: begin
        sv_q  <= sqa_q - sqb_q;
        res_q <= '0;
        bit_q <= 45'd1 << (2 * (SQRT_STEPS - 1));
      end
      OP_SQRTSTEP: begin
        if (45'(sv_q) >= trial) begin
          sv_q  <= sv_q - trial[43:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_SPR_CHK: begin
        ge_q <= (res_q >= {31'd0, fill_q, 8'd0});
        le_q <= 1'b0;
      end
      OP_SPR_PREP: begin
        rem_q <= 48'(res_q);
        dsh_q <= {35'd0, fill_q, 7'd0};
        quo_q <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      fill_q     <= '0;
      trend_q[0] <= 8'd128;
      trend_q[1] <= '0;
      trend_q[2] <= '0;
      trend_q[3] <= '0;
      spread_q   <= '0;
      weather_q  <= '0;
      day_q      <= '0;
      pat_out_q  <= '0;
      fresh_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_WRITE: begin
          slot_q <= (slot_q == IDX_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
          if (fill_q != CNT_W'(DEPTH)) fill_q <= fill_q + 1'b1;
        end
        OP_CHECK: fresh_q <= (fill_q >= CNT_W'(2));
        OP_PREP: begin
          if (ge_q) trend_q[cmd_i.chan] <= 8'd255;
          else if (le_q) trend_q[cmd_i.chan] <= 8'd0;
        end
        OP_TREND_DONE: trend_q[cmd_i.chan] <= quo_q;
        OP_SPR_PREP:   if (ge_q) spread_q <= 8'd255;
        OP_SPR_DONE:   spread_q <= quo_q;
        OP_FINAL: begin
          weather_q <= ws;
          day_q     <= dprod[18:11];
          pat_out_q <= pat_q;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.fill  = fill_q;
  assign sts_o.clamp = ge_q | le_q;

  assign snr_slope_o         = trend_q[0];
  assign latency_slope_o     = trend_q[1];
  assign loss_slope_o        = trend_q[2];
  assign obstruction_slope_o = trend_q[3];
  assign snr_spread_o        = spread_q;
  assign weather_score_o     = weather_q;
  assign day_fraction_o      = day_q;
  assign pattern_byte_o      = pat_out_q;
  assign features_fresh_o    = fresh_q;

endmodule

/* rtl/sliding_window_trend_features_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_trend_features_unit
// Sliding-window regression slope and spread features with weather scoring.
// ----------------------------------------------------------------------------
// Each item is stored in a 60-slot ring, then the unit sweeps the filled
// slots once through the single-port window memory, forms the least-squares
// slopes of four channels and the SNR spread with a shared divider
// and a square root, and presents one result item. A slope that saturates
// and a spread that is capped skip the divider, and while fewer than two
// slots are filled the sweep and the arithmetic are skipped. One item is
// in work at a time, and the next is taken once the result has been taken.
module sliding_window_trend_features_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swtf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 snr_value_i,
  input  logic [15:0]                 latency_value_i,
  input  logic [6:0]                  loss_percent_i,
  input  logic [6:0]                  obstruction_percent_i,
  input  logic [7:0]                  rain_amount_i,
  input  logic [7:0]                  wind_speed_i,
  input  logic [6:0]                  cloud_percent_i,
  input  logic [10:0]                 minute_of_day_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  snr_slope_o,
  output logic [7:0]                  snr_spread_o,
  output logic [7:0]                  latency_slope_o,
  output logic [7:0]                  loss_slope_o,
  output logic [7:0]                  obstruction_slope_o,
  output logic [6:0]                  weather_score_o,
  output logic [7:0]                  day_fraction_o,
  output logic [7:0]                  pattern_byte_o,
  output logic                        features_fresh_o
);
  import swtf_pkg::*;

  logic [15:0] trend_scale_q;
  logic [7:0]  wind_limit_q;
  logic [6:0]  cloud_limit_q;
  logic [1:0]  reg_idx;
  cmd_t        cmd;
  sts_t        sts;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trend_scale_q <= TREND_SCALE_RST;
      wind_limit_q  <= WIND_LIMIT_RST;
      cloud_limit_q <= CLOUD_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_TREND_SCALE: trend_scale_q <= pwdata[15:0];
        REG_WIND_LIMIT:  wind_limit_q  <= pwdata[7:0];
        REG_CLOUD_LIMIT: cloud_limit_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TREND_SCALE: prdata = {16'd0, trend_scale_q};
      REG_WIND_LIMIT:  prdata = {24'd0, wind_limit_q};
      REG_CLOUD_LIMIT: prdata = {25'd0, cloud_limit_q};
      default:         prdata = '0;
    endcase
  end

  swtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swtf_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .snr_value_i           (snr_value_i),
    .latency_value_i       (latency_value_i),
    .loss_percent_i        (loss_percent_i),
    .obstruction_percent_i (obstruction_percent_i),
    .rain_amount_i         (rain_amount_i),
    .wind_speed_i          (wind_speed_i),
    .cloud_percent_i       (cloud_percent_i),
    .minute_of_day_i       (minute_of_day_i),
    .trend_scale_i         (trend_scale_q),
    .wind_limit_i          (wind_limit_q),
    .cloud_limit_i         (cloud_limit_q),
    .snr_slope_o           (snr_slope_o),
    .snr_spread_o          (snr_spread_o),
    .latency_slope_o       (latency_slope_o),
    .loss_slope_o          (loss_slope_o),
    .obstruction_slope_o   (obstruction_slope_o),
    .weather_score_o       (weather_score_o),
    .day_fraction_o        (day_fraction_o),
    .pattern_byte_o        (pattern_byte_o),
    .features_fresh_o      (features_fresh_o)
  );

endmodule

/* test/tb_sliding_window_trend_features_unit.sv */
// ----------------------------------------------------------------------------
// tb_sliding_window_trend_features_unit
// Self-checking bench for the sliding-window trend feature unit.
// ----------------------------------------------------------------------------
// Items are sent through the valid/stall input channel and predicted by an
// integer model of the window, the regression slopes, the SNR spread, the
// weather score, the day fraction and the SNR pattern byte. Each result item
// is checked field by field against the oldest prediction. The run walks
// through several register settings written over the APB-style port, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_window_trend_features_unit;
  import swtf_pkg::*;

  localparam int unsigned SLOTS = 60;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [15:0] snr;
    logic [15:0] latency;
    logic [6:0]  loss;
    logic [6:0]  obstruction;
    logic [7:0]  rain;
    logic [7:0]  wind;
    logic [6:0]  cloud;
    logic [10:0] minute;
  } obs_t;

  typedef struct packed {
    logic [7:0] snr_slope;
    logic [7:0] snr_spread;
    logic [7:0] latency_slope;
    logic [7:0] loss_slope;
    logic [7:0] obstruction_slope;
    logic [6:0] weather_score;
    logic [7:0] day_fraction;
    logic [7:0] pattern_byte;
    logic       fresh;
  } feat_t;

  class trend_scoreboard;
    logic [15:0] win_snr [SLOTS];
    logic [15:0] win_lat [SLOTS];
    logic [6:0]  win_loss [SLOTS];
    logic [6:0]  win_obs [SLOTS];
    int unsigned fill;
    int unsigned slot;
    feat_t       held;
    logic [15:0] trend_scale;
    logic [7:0]  wind_limit;
    logic [6:0]  cloud_limit;
    feat_t       pending [$];
    bit          failed;

    function new();
      fill = 0;
      slot = 0;
      held = '0;
      held.snr_slope = 8'd128;
      trend_scale = TREND_SCALE_RST;
      wind_limit = WIND_LIMIT_RST;
      cloud_limit = CLOUD_LIMIT_RST;
      failed = 0;
    endfunction

    function logic [7:0] slope_code(longint num, longint den);
      longint d;
      d = den * longint'(trend_scale == 0 ? 16'd1 : trend_scale);
      if (num >= d) return 8'd255;
      if (num <= -d) return 8'd0;
      return 8'((255 * (num + d)) / (2 * d));
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_item(obs_t it);
      longint n, sx, sx2, den;
      longint sy [4];
      longint sxy [4];
      longint v [4];
      longint unsigned sq, spread;
      logic [7:0] pat;
      int unsigned ws, minute;
      feat_t r;
      win_snr[slot] = it.snr;
      win_lat[slot] = it.latency;
      win_loss[slot] = it.loss;
      win_obs[slot] = it.obstruction;
      slot = (slot + 1) % SLOTS;
      if (fill < SLOTS) fill++;
      if (fill >= 2) begin
        n = fill;
        sx = 0;
        sx2 = 0;
        sq = 0;
        pat = 0;
        for (int c = 0; c < 4; c++) begin
          sy[c] = 0;
          sxy[c] = 0;
        end
        for (int i = 0; i < fill; i++) begin
          v[0] = win_snr[i];
          v[1] = win_lat[i];
          v[2] = win_loss[i];
          v[3] = win_obs[i];
          sx += i;
          sx2 += i * i;
          for (int c = 0; c < 4; c++) begin
            sy[c] += v[c];
            sxy[c] += i * v[c];
          end
          sq += longint'(win_snr[i]) * longint'(win_snr[i]);
          pat ^= win_snr[i][7:0];
        end
        den = n * sx2 - sx * sx;
        held.snr_slope = slope_code(n * sxy[0] - sx * sy[0], den);
        held.latency_slope = slope_code(n * sxy[1] - sx * sy[1], den);
        held.loss_slope = slope_code(n * sxy[2] - sx * sy[2], den);
        held.obstruction_slope = slope_code(n * sxy[3] - sx * sy[3], den);
        spread = isqrt(longint'(n) * sq - longint'(sy[0]) * longint'(sy[0])) / n;
        held.snr_spread = spread > 255 ? 8'd255 : 8'(spread);
        ws = 0;
        if (it.rain != 0) ws += 50;
        if (it.wind > wind_limit) ws += 30;
        if (it.cloud > cloud_limit) ws += 20;
        held.weather_score = 7'(ws);
        minute = it.minute > 1439 ? 1439 : it.minute;
        held.day_fraction = 8'(minute * 255 / 1440);
        held.pattern_byte = pat;
      end
      r = held;
      r.fresh = fill >= 2;
      pending.push_back(r);
    endfunction

    function void check_result(feat_t got);
      feat_t e;
      if (pending.size() == 0) begin
        $error("result item with no prediction waiting");
        failed = 1;
        return;
      end
      e = pending.pop_front();
      if (got.snr_slope !== e.snr_slope) begin
        $error("snr_slope expected %0d got %0d", e.snr_slope, got.snr_slope);
        failed = 1;
      end
      if (got.snr_spread !== e.snr_spread) begin
        $error("snr_spread expected %0d got %0d", e.snr_spread, got.snr_spread);
        failed = 1;
      end
      if (got.latency_slope !== e.latency_slope) begin
        $error("latency_slope expected %0d got %0d", e.latency_slope, got.latency_slope);
        failed = 1;
      end
      if (got.loss_slope !== e.loss_slope) begin
        $error("loss_slope expected %0d got %0d", e.loss_slope, got.loss_slope);
        failed = 1;
      end
      if (got.obstruction_slope !== e.obstruction_slope) begin
        $error("obstruction_slope expected %0d got %0d", e.obstruction_slope,
               got.obstruction_slope);
        failed = 1;
      end
      if (got.weather_score !== e.weather_score) begin
        $error("weather_score expected %0d got %0d", e.weather_score, got.weather_score);
        failed = 1;
      end
      if (got.day_fraction !== e.day_fraction) begin
        $error("day_fraction expected %0d got %0d", e.day_fraction, got.day_fraction);
        failed = 1;
      end
      if (got.pattern_byte !== e.pattern_byte) begin
        $error("pattern_byte expected %0d got %0d", e.pattern_byte, got.pattern_byte);
        failed = 1;
      end
      if (got.fresh !== e.fresh) begin
        $error("features_fresh expected %0d got %0d", e.fresh, got.fresh);
        failed = 1;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  obs_t obs = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  feat_t got;

  trend_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  longint unsigned cycles = 0;

  sliding_window_trend_features_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .snr_value_i(obs.snr), .latency_value_i(obs.latency), .loss_percent_i(obs.loss),
    .obstruction_percent_i(obs.obstruction), .rain_amount_i(obs.rain),
    .wind_speed_i(obs.wind), .cloud_percent_i(obs.cloud),
    .minute_of_day_i(obs.minute),
    .out_valid_o, .out_stall_i,
    .snr_slope_o(got.snr_slope), .snr_spread_o(got.snr_spread),
    .latency_slope_o(got.latency_slope), .loss_slope_o(got.loss_slope),
    .obstruction_slope_o(got.obstruction_slope), .weather_score_o(got.weather_score),
    .day_fraction_o(got.day_fraction), .pattern_byte_o(got.pattern_byte),
    .features_fresh_o(got.fresh)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sliding_window_trend_features_unit NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_request;
      hold_request = 0;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(got);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TREND_SCALE: sb.trend_scale = val[15:0];
      REG_WIND_LIMIT:  sb.wind_limit = val[7:0];
      REG_CLOUD_LIMIT: sb.cloud_limit = val[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_item(obs_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    obs <= it;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
      @(posedge clk_i);
    end
    sb.note_item(it);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic obs_t random_obs(bit full);
    obs_t it;
    it = '0;
    it.snr = 16'($urandom);
    it.latency = 16'($urandom);
    it.rain = $urandom_range(3) == 0 ? 8'd0 : 8'($urandom);
    it.wind = 8'($urandom);
    if (full) begin
      it.loss = 7'($urandom);
      it.obstruction = 7'($urandom);
      it.cloud = 7'($urandom);
      it.minute = 11'($urandom);
    end else begin
      it.loss = 7'($urandom_range(100));
      it.obstruction = 7'($urandom_range(100));
      it.cloud = 7'($urandom_range(100));
      it.minute = 11'($urandom_range(1439));
    end
    return it;
  endfunction

  task automatic random_phase(int unsigned count);
    obs_t it;
    int unsigned k;
    int signed step;
    k = 0;
    while (k < count) begin
      if ($urandom_range(2) == 0) begin
        step = int'($urandom_range(2000)) - 1000;
        for (int j = 0; j < 20 && k < count; j++, k++) begin
          it = random_obs(0);
          it.snr = 16'(32768 + step * j + int'($urandom_range(50)));
          it.latency = 16'(32768 - step * j);
          it.loss = 7'(step > 0 ? j * 5 : 100 - j * 5);
          it.obstruction = 7'($urandom_range(3) + (step > 0 ? 0 : j * 4));
          send_item(it);
        end
      end else begin
        send_item(random_obs($urandom_range(4) == 0));
        k++;
      end
    end
    drain();
  endtask

  initial begin
    obs_t it;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < 20; k++) begin
      it.snr = k == 19 ? 16'hFFFF : 16'(k * 3000);
      it.latency = 16'(65535 - k * 3000);
      it.loss = k == 18 ? 7'd127 : 7'(k * 5);
      it.obstruction = 7'(100 - k * 5);
      it.rain = k % 3 == 0 ? 8'd0 : (k % 3 == 1 ? 8'd255 : 8'd1);
      it.wind = k % 4 == 0 ? 8'd10 : (k % 4 == 1 ? 8'd11 : (k % 4 == 2 ? 8'd255 : 8'd0));
      it.cloud = k % 5 == 0 ? 7'd80 : (k % 5 == 1 ? 7'd81 : (k % 5 == 2 ? 7'd127 : 7'd0));
      it.minute = k % 4 == 0 ? 11'd0 : (k % 4 == 1 ? 11'd1439 :
                  (k % 4 == 2 ? 11'd1440 : 11'd2047));
      send_item(it);
    end
    drain();

    write_reg(REG_TREND_SCALE, 32'd1);
    write_reg(REG_WIND_LIMIT, 32'd0);
    write_reg(REG_CLOUD_LIMIT, 32'd0);
    send_idle_pct = 19;
    recv_stall_pct = 70;
    random_phase(380);

    write_reg(REG_TREND_SCALE, 32'd65535);
    write_reg(REG_WIND_LIMIT, 32'd255);
    write_reg(REG_CLOUD_LIMIT, 32'd127);
    send_idle_pct = 70;
    recv_stall_pct = 19;
    random_phase(380);

    write_reg(REG_TREND_SCALE, 32'd0);
    write_reg(REG_WIND_LIMIT, 32'($urandom_range(255)));
    write_reg(REG_CLOUD_LIMIT, 32'd100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 3000;
    random_phase(380);

    write_reg(REG_TREND_SCALE, 32'($urandom_range(1, 200)));
    write_reg(REG_WIND_LIMIT, 32'($urandom_range(255)));
    write_reg(REG_CLOUD_LIMIT, 32'($urandom_range(100)));
    random_phase(390);

    if (!sb.failed) begin
      $display("tb_sliding_window_trend_features_unit OK");
    end else begin
      $display("tb_sliding_window_trend_features_unit NOT OK");
    end
    $finish;
  end

endmodule

/* sliding_window_trend_features_unit.f */
rtl/swtf_pkg.sv
rtl/swtf_ctrl.sv
rtl/swtf_dp.sv
rtl/sliding_window_trend_features_unit.sv
test/tb_sliding_window_trend_features_unit.sv
